// ===== rtl/mau_pkg.sv =====
// shared types and constants for the modular arithmetic unit
`timescale 1ns / 1ps
package mau_pkg;

    localparam int unsigned WORD_W        = 31;
    localparam int unsigned MAX_N_DEFAULT = 1024;
    localparam logic [WORD_W-1:0] MODULUS_RESET = 31'd7;

    localparam logic [2:0] MODE_ADD     = 3'd0;
    localparam logic [2:0] MODE_SUB     = 3'd1;
    localparam logic [2:0] MODE_MUL     = 3'd2;
    localparam logic [2:0] MODE_POW     = 3'd3;
    localparam logic [2:0] MODE_INV     = 3'd4;
    localparam logic [2:0] MODE_DIV     = 3'd5;
    localparam logic [2:0] MODE_CHOOSE  = 3'd6;
    localparam logic [2:0] MODE_PERMUTE = 3'd7;

    typedef enum logic [3:0] {
        S_IDLE, S_RB, S_DISP, S_F0, S_F1, S_F2, S_F3,
        S_PCHK, S_PSQ, S_TB0, S_TB1, S_TB2, S_MUL
    } t_state;

    typedef enum logic [2:0] {
        DST_A, DST_B, DST_ACC, DST_BASE, DST_TBL
    } t_dst;

endpackage

// ===== rtl/mau_ram.sv =====
// generic single-port ram with registered read
`timescale 1ns / 1ps
module mau_ram #(
    parameter int unsigned WIDTH = 31,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

// ===== rtl/mau_mulmod.sv =====
// bit-serial modular multiplier, one bit of y per cycle, x must be below p
`timescale 1ns / 1ps
module mau_mulmod (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [mau_pkg::WORD_W-1:0] i_x,
    input  logic [mau_pkg::WORD_W-1:0] i_y,
    input  logic [mau_pkg::WORD_W-1:0] i_p,
    output logic                       o_done,
    output logic [mau_pkg::WORD_W-1:0] o_z
);

    logic                       r_run;
    logic                       r_done;
    logic [4:0]                 r_cnt;
    logic [mau_pkg::WORD_W-1:0] r_x;
    logic [mau_pkg::WORD_W-1:0] r_y;
    logic [mau_pkg::WORD_W-1:0] r_z;
    logic [mau_pkg::WORD_W:0]   dbl;
    logic [mau_pkg::WORD_W:0]   dbl_red;
    logic [mau_pkg::WORD_W:0]   sum;
    logic [mau_pkg::WORD_W:0]   sum_red;
    logic [mau_pkg::WORD_W:0]   p_ext;

    always_comb begin
        p_ext   = {1'b0, i_p};
        dbl     = {r_z, 1'b0};
        dbl_red = (dbl >= p_ext) ? dbl - p_ext : dbl;
        sum     = dbl_red + (r_y[mau_pkg::WORD_W-1] ? {1'b0, r_x} : '0);
        sum_red = (sum >= p_ext) ? sum - p_ext : sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_run && (r_cnt == 5'd0);
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && r_cnt == 5'd0) begin
                r_run <= 1'b0;
            end
        end
        if (i_start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_z   <= '0;
            r_cnt <= 5'(mau_pkg::WORD_W - 1);
        end else if (r_run) begin
            r_z   <= sum_red[mau_pkg::WORD_W-1:0];
            r_y   <= {r_y[mau_pkg::WORD_W-2:0], 1'b0};
            r_cnt <= r_cnt - 5'd1;
        end
    end

    assign o_done = r_done;
    assign o_z    = r_z;

endmodule

// ===== rtl/modular_arithmetic_unit.sv =====
// modular arithmetic unit: top level with sequencer and factorial table
// one modular multiply holds S_MUL through start, 31 bit steps and done; the strobe follows the
// accepting edge: add/sub run two operand reductions, while mul, pow, inverse and divide
// loop per exponent bit (check, multiply if set, square) and choose reads the factorial table
// one word at a time, start ignored while busy, results cannot be stalled; reset and every
// modulus write rebuild the table one entry after another, busy stays high meanwhile
`timescale 1ns / 1ps
module modular_arithmetic_unit #(
    parameter int unsigned MAX_N = mau_pkg::MAX_N_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [2:0]                 i_mode,
    input  logic [mau_pkg::WORD_W-1:0] i_operand_a,
    input  logic [mau_pkg::WORD_W-1:0] i_operand_b,
    output logic                       o_valid,
    output logic [mau_pkg::WORD_W-1:0] o_result,
    output logic                       o_status,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [mau_pkg::WORD_W-1:0] i_cfg_data
);

    localparam int unsigned AW = $clog2(MAX_N);
    localparam int unsigned W  = mau_pkg::WORD_W;

    mau_pkg::t_state r_state, n_state, r_ret;
    mau_pkg::t_dst   r_dst;

    logic [W-1:0]  r_p, r_ra, r_rb, r_a, r_b, r_acc, r_base, r_t, r_e;
    logic [W-1:0]  r_prev, r_im, r_mx, r_my, r_res;
    logic [2:0]    r_mode;
    logic          r_more, r_mstart, r_valid, r_stat;
    logic [AW-1:0] r_i;

    // multiplier and table ram
    logic          mul_done;
    logic [W-1:0]  mul_z;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [W-1:0]  ram_wdata, ram_rdata;

    // decisions shared by next-state and register logic
    logic          take_cfg, take_start;
    logic          arg_err, f3_zero;
    logic [W:0]    add_s, sub_s, p_ext;
    logic [W-1:0]  add_r, sub_r, p_m2, e_half;

    mau_mulmod u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mstart),
        .i_x     (r_mx),
        .i_y     (r_my),
        .i_p     (r_p),
        .o_done  (mul_done),
        .o_z     (mul_z)
    );

    mau_ram #(.WIDTH(W), .DEPTH(MAX_N)) u_ftab (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        take_cfg   = (r_state == mau_pkg::S_IDLE) && i_cfg_valid;
        take_start = (r_state == mau_pkg::S_IDLE) && !i_cfg_valid && start;
        p_ext      = {1'b0, r_p};
        add_s      = {1'b0, r_a} + {1'b0, r_b};
        add_r      = (add_s >= p_ext) ? W'(add_s - p_ext) : add_s[W-1:0];
        sub_s      = {1'b0, r_a} + p_ext - {1'b0, r_b};
        sub_r      = (sub_s >= p_ext) ? W'(sub_s - p_ext) : sub_s[W-1:0];
        p_m2       = r_p - W'(2);
        e_half     = {1'b0, r_e[W-1:1]};
        // n beyond the table or r above n
        arg_err    = ({1'b0, r_ra} >= (W+1)'(MAX_N)) || (r_rb > r_ra);
        // a zero factorial has no inverse, the product is then zero
        f3_zero    = (r_base == '0) ||
                     ((r_mode == mau_pkg::MODE_CHOOSE) && (ram_rdata == '0));
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mau_pkg::S_IDLE: begin
                if (take_cfg) begin
                    n_state = mau_pkg::S_TB0;
                end else if (take_start) begin
                    n_state = mau_pkg::S_MUL;
                end
            end
            mau_pkg::S_RB: n_state = mau_pkg::S_MUL;
            mau_pkg::S_DISP: begin
                unique case (r_mode)
                    mau_pkg::MODE_ADD, mau_pkg::MODE_SUB: n_state = mau_pkg::S_IDLE;
                    mau_pkg::MODE_MUL, mau_pkg::MODE_POW: n_state = mau_pkg::S_PCHK;
                    mau_pkg::MODE_INV:
                        n_state = (r_a == '0) ? mau_pkg::S_IDLE : mau_pkg::S_PCHK;
                    mau_pkg::MODE_DIV:
                        n_state = (r_b == '0) ? mau_pkg::S_IDLE : mau_pkg::S_PCHK;
                    default: n_state = arg_err ? mau_pkg::S_IDLE : mau_pkg::S_F0;
                endcase
            end
            mau_pkg::S_F0: n_state = mau_pkg::S_F1;
            mau_pkg::S_F1: n_state = mau_pkg::S_F2;
            mau_pkg::S_F2: n_state = mau_pkg::S_F3;
            mau_pkg::S_F3: n_state = f3_zero ? mau_pkg::S_IDLE : mau_pkg::S_PCHK;
            mau_pkg::S_PCHK: begin
                if (r_e == '0) begin
                    n_state = r_more ? mau_pkg::S_PCHK : mau_pkg::S_IDLE;
                end else if (r_e[0]) begin
                    n_state = mau_pkg::S_MUL;
                end else begin
                    n_state = mau_pkg::S_PSQ;
                end
            end
            mau_pkg::S_PSQ:
                n_state = (e_half == '0) ? mau_pkg::S_PCHK : mau_pkg::S_MUL;
            mau_pkg::S_TB0: n_state = mau_pkg::S_TB1;
            mau_pkg::S_TB1: n_state = mau_pkg::S_MUL;
            mau_pkg::S_TB2:
                n_state = (r_i == AW'(MAX_N - 1)) ? mau_pkg::S_IDLE : mau_pkg::S_TB1;
            mau_pkg::S_MUL: n_state = mul_done ? r_ret : mau_pkg::S_MUL;
            default: n_state = mau_pkg::S_IDLE;
        endcase
    end

    // table ram port and handshake outputs
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_i;
        ram_wdata = mul_z;
        unique case (r_state)
            mau_pkg::S_TB0: begin
                ram_we    = 1'b1;
                ram_addr  = '0;
                ram_wdata = W'(1);
            end
            mau_pkg::S_MUL: ram_we = mul_done && (r_dst == mau_pkg::DST_TBL);
            mau_pkg::S_F0:  ram_addr = r_ra[AW-1:0];
            mau_pkg::S_F1:  ram_addr = AW'(r_ra - r_rb);
            mau_pkg::S_F2:  ram_addr = r_rb[AW-1:0];
            default: ram_addr = r_i;
        endcase
        busy        = (r_state != mau_pkg::S_IDLE) || i_cfg_valid;
        o_cfg_ready = (r_state == mau_pkg::S_IDLE);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mau_pkg::S_TB0;
            r_p      <= mau_pkg::MODULUS_RESET;
            r_mstart <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mstart <= (n_state == mau_pkg::S_MUL) && (r_state != mau_pkg::S_MUL);
            // result strobe when an item finishes back to idle
            r_valid  <= (r_state != mau_pkg::S_IDLE) && (r_state != mau_pkg::S_TB2) &&
                        (r_state != mau_pkg::S_MUL) && (n_state == mau_pkg::S_IDLE);
            if (take_cfg) begin
                // modulus below two saturates to two
                r_p <= (i_cfg_data < W'(2)) ? W'(2) : i_cfg_data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            mau_pkg::S_IDLE: begin
                if (take_start) begin
                    // reduce operand a as a * 1 mod p
                    r_mode <= i_mode;
                    r_ra   <= i_operand_a;
                    r_rb   <= i_operand_b;
                    r_mx   <= W'(1);
                    r_my   <= i_operand_a;
                    r_dst  <= mau_pkg::DST_A;
                    r_ret  <= mau_pkg::S_RB;
                end
            end
            mau_pkg::S_RB: begin
                r_mx  <= W'(1);
                r_my  <= r_rb;
                r_dst <= mau_pkg::DST_B;
                r_ret <= mau_pkg::S_DISP;
            end
            mau_pkg::S_DISP: begin
                r_stat <= 1'b0;
                r_res  <= '0;
                r_more <= 1'b0;
                unique case (r_mode)
                    mau_pkg::MODE_ADD: r_res <= add_r;
                    mau_pkg::MODE_SUB: r_res <= sub_r;
                    mau_pkg::MODE_MUL: begin
                        r_acc  <= r_a;
                        r_base <= r_b;
                        r_e    <= W'(1);
                    end
                    mau_pkg::MODE_POW: begin
                        // exponent taken unreduced
                        r_acc  <= W'(1);
                        r_base <= r_a;
                        r_e    <= r_rb;
                    end
                    mau_pkg::MODE_INV: begin
                        r_acc  <= W'(1);
                        r_base <= r_a;
                        r_e    <= p_m2;
                    end
                    mau_pkg::MODE_DIV: begin
                        r_acc  <= r_a;
                        r_base <= r_b;
                        r_e    <= p_m2;
                    end
                    default: r_stat <= arg_err;
                endcase
            end
            mau_pkg::S_F0: ;
            mau_pkg::S_F1: r_acc  <= ram_rdata;
            mau_pkg::S_F2: r_base <= ram_rdata;
            mau_pkg::S_F3: begin
                r_t    <= ram_rdata;
                r_e    <= p_m2;
                r_more <= (r_mode == mau_pkg::MODE_CHOOSE);
                r_res  <= '0;
            end
            mau_pkg::S_PCHK: begin
                if (r_e == '0) begin
                    if (r_more) begin
                        // second inverse term of choose
                        r_base <= r_t;
                        r_e    <= p_m2;
                        r_more <= 1'b0;
                    end else begin
                        r_res <= r_acc;
                    end
                end else if (r_e[0]) begin
                    r_mx  <= r_acc;
                    r_my  <= r_base;
                    r_dst <= mau_pkg::DST_ACC;
                    r_ret <= mau_pkg::S_PSQ;
                end
            end
            mau_pkg::S_PSQ: begin
                r_e   <= e_half;
                r_mx  <= r_base;
                r_my  <= r_base;
                r_dst <= mau_pkg::DST_BASE;
                r_ret <= mau_pkg::S_PCHK;
            end
            mau_pkg::S_TB0: begin
                r_prev <= W'(1);
                r_im   <= W'(1);
                r_i    <= AW'(1);
            end
            mau_pkg::S_TB1: begin
                r_mx  <= r_prev;
                r_my  <= r_im;
                r_dst <= mau_pkg::DST_TBL;
                r_ret <= mau_pkg::S_TB2;
            end
            mau_pkg::S_TB2: begin
                // running index mod p, no divider needed
                r_i  <= r_i + AW'(1);
                r_im <= (r_im + W'(1) == r_p) ? '0 : r_im + W'(1);
            end
            mau_pkg::S_MUL: begin
                if (mul_done) begin
                    unique case (r_dst)
                        mau_pkg::DST_A:    r_a    <= mul_z;
                        mau_pkg::DST_B:    r_b    <= mul_z;
                        mau_pkg::DST_ACC:  r_acc  <= mul_z;
                        mau_pkg::DST_BASE: r_base <= mul_z;
                        default:           r_prev <= mul_z;
                    endcase
                end
            end
            default: ;
        endcase
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;
    assign o_status = r_stat;

endmodule
